### hdl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and request/response types for the quaternion vector
// rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

   localparam int COMPONENT_WIDTH = 16;
   localparam int FRAC_BITS       = COMPONENT_WIDTH - 2;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_type;

   typedef struct packed {
      comp_type rot_x;
      comp_type rot_y;
      comp_type rot_z;
      comp_type rot_w;
      comp_type pos_x;
      comp_type pos_y;
      comp_type pos_z;
   } req_type;

   typedef struct packed {
      comp_type out_x;
      comp_type out_y;
      comp_type out_z;
      comp_type out_w;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/qvr_norm.sv
// ----------------------------------------------------------------------------
// qvr_norm
// Pipelined normalization of a four-component tuple: magnitude prescale,
// squares, sum, bit-per-stage square root, then four lanes of bit-per-stage
// rounded division. A zero tuple passes through as zero. A side tag rides
// along with each request.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_norm
   import qvr_pkg::*;
#(
   parameter int IW    = COMPONENT_WIDTH,
   parameter int TAG_W = 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire logic [3:0][IW-1:0]               in_c,
   input  wire logic [TAG_W-1:0]                 in_tag,
   output logic                                  out_valid,
   output logic [3:0][COMPONENT_WIDTH-1:0]       out_c,
   output logic [TAG_W-1:0]                      out_tag
);

   localparam int W    = COMPONENT_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int AW   = (IW > 31) ? 31 : IW;
   localparam int KMAX = IW - AW;
   localparam int SW   = 2 * AW + 2;
   localparam int SW1  = SW + 1;
   localparam int RB   = AW + 1;
   localparam int QB   = F + 1;
   localparam int NB   = AW + F + 1;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [3:0]       neg;
      logic             zero;
   } side_type;

   // magnitudes and prescale
   logic [3:0][IW-1:0] mag;
   logic [3:0]         neg;
   logic [3:0][AW-1:0] amag;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg[i] = in_c[i][IW-1];
         mag[i] = neg[i] ? (~in_c[i] + 1'b1) : in_c[i];
      end
   end

   if (KMAX == 0) begin : g_noshift
      assign amag = mag;
   end else begin : g_shift
      localparam int KB = $clog2(KMAX + 1);
      logic [IW-1:0] mag_or;
      logic [KB-1:0] k;
      always_comb begin
         mag_or = '0;
         for (int i = 0; i < 4; i++) mag_or = mag_or | mag[i];
         k = '0;
         // smallest shift that brings every magnitude below 2^31
         for (int j = 0; j < KMAX; j++) begin
            if (mag_or[31 + j]) k = KB'(j + 1);
         end
         for (int i = 0; i < 4; i++) amag[i] = AW'(mag[i] >> k);
      end
   end

   logic                 p0_valid_ff, p1_valid_ff;
   side_type             p0_side_ff, p1_side_ff;
   logic [3:0][AW-1:0]   p0_mag_ff, p1_mag_ff;
   logic [3:0][2*AW-1:0] p1_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= in_valid;
         p1_valid_ff <= p0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_side_ff.tag  <= in_tag;
         p0_side_ff.neg  <= neg;
         p0_side_ff.zero <= 1'b0;
         p0_mag_ff       <= amag;
         p1_side_ff      <= p0_side_ff;
         p1_mag_ff       <= p0_mag_ff;
         for (int i = 0; i < 4; i++) begin
            p1_sq_ff[i] <= p0_mag_ff[i] * p0_mag_ff[i];
         end
      end
   end

   // square root, one result bit per stage
   logic               sq_valid_ff [RB+1];
   side_type           sq_side_ff  [RB+1];
   logic [SW-1:0]      sq_rem_ff   [RB+1];
   logic [RB-1:0]      sq_root_ff  [RB+1];
   logic [3:0][AW-1:0] sq_mag_ff   [RB+1];
   logic [SW-1:0]      sq_sum;

   always_comb begin
      sq_sum = '0;
      for (int i = 0; i < 4; i++) sq_sum = sq_sum + SW'(p1_sq_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (en) begin
         sq_valid_ff[0] <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0].tag  <= p1_side_ff.tag;
         sq_side_ff[0].neg  <= p1_side_ff.neg;
         sq_side_ff[0].zero <= (sq_sum == '0);
         sq_rem_ff[0]       <= sq_sum;
         sq_root_ff[0]      <= '0;
         sq_mag_ff[0]       <= p1_mag_ff;
      end
   end

   for (genvar s = 0; s < RB; s++) begin : g_sqrt
      localparam int B = RB - 1 - s;
      logic [SW:0] trial;
      logic        take;

      always_comb begin
         // (root + 2^B)^2 - root^2
         trial = ({1'b0, SW'(sq_root_ff[s])} << (B + 1)) + (SW1'(1) << (2 * B));
         take  = ({1'b0, sq_rem_ff[s]} >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[s+1] <= sq_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_side_ff[s+1] <= sq_side_ff[s];
            sq_mag_ff[s+1]  <= sq_mag_ff[s];
            if (take) begin
               sq_rem_ff[s+1]  <= sq_rem_ff[s] - trial[SW-1:0];
               sq_root_ff[s+1] <= sq_root_ff[s] | (RB'(1) << B);
            end else begin
               sq_rem_ff[s+1]  <= sq_rem_ff[s];
               sq_root_ff[s+1] <= sq_root_ff[s];
            end
         end
      end
   end

   // rounded division, four lanes, one quotient bit per stage
   logic               dv_valid_ff [QB+1];
   side_type           dv_side_ff  [QB+1];
   logic [RB-1:0]      dv_div_ff   [QB+1];
   logic [3:0][RB-1:0] dv_rem_ff   [QB+1];
   logic [3:0][QB-1:0] dv_low_ff   [QB+1];
   logic [3:0][QB-1:0] dv_quo_ff   [QB+1];
   logic [3:0][NB-1:0] num;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num[i] = (NB'(sq_mag_ff[RB][i]) << F) + NB'(sq_root_ff[RB] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= sq_valid_ff[RB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0] <= sq_side_ff[RB];
         dv_div_ff[0]  <= sq_root_ff[RB];
         for (int i = 0; i < 4; i++) begin
            // quotient fits QB bits, so the upper part starts below the divisor
            dv_rem_ff[0][i] <= RB'(num[i] >> QB);
            dv_low_ff[0][i] <= num[i][QB-1:0];
            dv_quo_ff[0][i] <= '0;
         end
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_div
      localparam int B = QB - 1 - s;
      logic [RB:0] part [4];
      logic [3:0]  take;

      always_comb begin
         for (int i = 0; i < 4; i++) begin
            part[i] = {dv_rem_ff[s][i], dv_low_ff[s][i][B]};
            take[i] = (part[i] >= {1'b0, dv_div_ff[s]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_side_ff[s+1] <= dv_side_ff[s];
            dv_div_ff[s+1]  <= dv_div_ff[s];
            dv_low_ff[s+1]  <= dv_low_ff[s];
            for (int i = 0; i < 4; i++) begin
               if (take[i]) begin
                  dv_rem_ff[s+1][i] <= RB'(part[i] - {1'b0, dv_div_ff[s]});
                  dv_quo_ff[s+1][i] <= dv_quo_ff[s][i] | (QB'(1) << B);
               end else begin
                  dv_rem_ff[s+1][i] <= RB'(part[i]);
                  dv_quo_ff[s+1][i] <= dv_quo_ff[s][i];
               end
            end
         end
      end
   end

   // restore signs, drop a zero tuple to zero
   logic                out_valid_ff;
   logic [3:0][W-1:0]   out_c_ff;
   logic [TAG_W-1:0]    out_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_tag_ff <= dv_side_ff[QB].tag;
         for (int i = 0; i < 4; i++) begin
            if (dv_side_ff[QB].zero) begin
               out_c_ff[i] <= '0;
            end else if (dv_side_ff[QB].neg[i]) begin
               out_c_ff[i] <= W'(0) - W'(dv_quo_ff[QB][i]);
            end else begin
               out_c_ff[i] <= W'(dv_quo_ff[QB][i]);
            end
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_c     = out_c_ff;
   assign out_tag   = out_tag_ff;

endmodule

`default_nettype wire

### hdl/quaternion_vector_rotation.sv
// Accepts one request per cycle while the response is not stalled.
// Path: normalize vector, Hamilton product, normalize, Hamilton product,
// normalize, normalize, response register. Square root and division stages
// set most of the depth, one result bit per stage. A stalled response freezes
// the whole pipeline. Reset clears all valid bits.
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a vector by conj(q) * v * q in fixed point, normalizing the vector,
// each product and the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotation
   import qvr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int W  = COMPONENT_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W + 2;
   localparam int HW = W + 3;

   // minus signs of the Hamilton terms, [component][term]
   localparam logic [3:0][3:0] HAM_NEG = {4'b0111, 4'b0010, 4'b0001, 4'b0100};
   localparam logic signed [PW-1:0] RND = PW'(64'd1 << (F - 1));

   logic en;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // normalize the incoming vector, carry the rotation alongside
   logic [3:0][W-1:0] pos_in, rot_in;
   logic              n0_valid;
   logic [3:0][W-1:0] n0_c, n0_q;

   assign pos_in = {W'(0), req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign rot_in = {req_data.rot_w, req_data.rot_z, req_data.rot_y, req_data.rot_x};

   qvr_norm #(.IW(W), .TAG_W(4 * W)) u_norm_pos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_c      (pos_in),
      .in_tag    (rot_in),
      .out_valid (n0_valid),
      .out_c     (n0_c),
      .out_tag   (n0_q)
   );

   // two Hamilton product units: conj(q) * v, then r1 * q
   logic [1:0]                ham_in_valid;
   logic [1:0][3:0][W:0]      ham_a, ham_b;
   logic [1:0][3:0][W-1:0]    ham_in_q;
   logic [1:0]                ham_out_valid;
   logic [1:0][3:0][HW-1:0]   ham_out;
   logic [1:0][3:0][W-1:0]    ham_out_q;

   logic              n1_valid;
   logic [3:0][W-1:0] n1_c, n1_q;

   always_comb begin
      ham_in_valid[0] = n0_valid;
      ham_in_q[0]     = n0_q;
      ham_in_valid[1] = n1_valid;
      ham_in_q[1]     = n1_q;
      for (int c = 0; c < 4; c++) begin
         if (c < 3) begin
            ham_a[0][c] = -$signed({n0_q[c][W-1], n0_q[c]});
         end else begin
            ham_a[0][c] = {n0_q[c][W-1], n0_q[c]};
         end
         ham_b[0][c] = {n0_c[c][W-1], n0_c[c]};
         ham_a[1][c] = {n1_c[c][W-1], n1_c[c]};
         ham_b[1][c] = {n1_q[c][W-1], n1_q[c]};
      end
   end

   for (genvar h = 0; h < 2; h++) begin : g_ham
      logic                   prod_valid_ff, sum_valid_ff;
      logic signed [PW-1:0]   prod_ff [16];
      logic [3:0][W-1:0]      prod_q_ff, sum_q_ff;
      logic [3:0][HW-1:0]     sum_ff;
      logic signed [HW-1:0]   sum_in [4];
      logic signed [PW-1:0]   rnd_p;
      logic signed [HW-1:0]   term;

      always_ff @(posedge clock) begin
         if (reset) begin
            prod_valid_ff <= 1'b0;
            sum_valid_ff  <= 1'b0;
         end else if (en) begin
            prod_valid_ff <= ham_in_valid[h];
            sum_valid_ff  <= prod_valid_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            prod_q_ff <= ham_in_q[h];
            for (int c = 0; c < 4; c++) begin
               for (int t = 0; t < 4; t++) begin
                  prod_ff[c*4+t] <= PW'($signed(ham_a[h][t])
                                        * $signed(ham_b[h][t ^ (3 - c)]));
               end
            end
         end
      end

      // round each term half up, then sum
      always_comb begin
         rnd_p = '0;
         term  = '0;
         for (int c = 0; c < 4; c++) begin
            sum_in[c] = '0;
            for (int t = 0; t < 4; t++) begin
               rnd_p = prod_ff[c*4+t] + RND;
               term  = HW'(rnd_p >>> F);
               if (HAM_NEG[c][t]) begin
                  sum_in[c] = sum_in[c] - term;
               end else begin
                  sum_in[c] = sum_in[c] + term;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sum_q_ff <= prod_q_ff;
            for (int c = 0; c < 4; c++) sum_ff[c] <= sum_in[c];
         end
      end

      assign ham_out_valid[h] = sum_valid_ff;
      assign ham_out[h]       = sum_ff;
      assign ham_out_q[h]     = sum_q_ff;
   end

   qvr_norm #(.IW(HW), .TAG_W(4 * W)) u_norm_first (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ham_out_valid[0]),
      .in_c      (ham_out[0]),
      .in_tag    (ham_out_q[0]),
      .out_valid (n1_valid),
      .out_c     (n1_c),
      .out_tag   (n1_q)
   );

   logic              n2_valid;
   logic [3:0][W-1:0] n2_c;

   qvr_norm #(.IW(HW), .TAG_W(1)) u_norm_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ham_out_valid[1]),
      .in_c      (ham_out[1]),
      .in_tag    (1'b0),
      .out_valid (n2_valid),
      .out_c     (n2_c),
      .out_tag   ()
   );

   logic              n3_valid;
   logic [3:0][W-1:0] n3_c;

   qvr_norm #(.IW(W), .TAG_W(1)) u_norm_final (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n2_valid),
      .in_c      (n2_c),
      .in_tag    (1'b0),
      .out_valid (n3_valid),
      .out_c     (n3_c),
      .out_tag   ()
   );

   // response register, held while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= n3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.out_x <= n3_c[0];
         rsp_data_ff.out_y <= n3_c[1];
         rsp_data_ff.out_z <= n3_c[2];
         rsp_data_ff.out_w <= n3_c[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
